// ===== sv/prdt_pkg.sv =====
// page-region descriptor table: shared types, status codes and default sizes
// no dependencies; used by page_region_descriptor_table_core and its testbench
package prdt_pkg;

   localparam int GROUPS_DEF          = 64;
   localparam int SLOTS_PER_GROUP_DEF = 64;
   localparam int FRAME_BITS_DEF      = 40;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NO_PAGE = 2'd2;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_ALLOC  = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_REC    = 7'b0000010,
      S_MSCAN  = 7'b0000100,
      S_INS_RD = 7'b0001000,
      S_INS_WR = 7'b0010000,
      S_ASCAN  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

endpackage

// ===== sv/prdt_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
// depends on nothing; instantiated by page_region_descriptor_table_core
module prdt_ram #(
   parameter int WIDTH = 81,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [2**AW];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/page_region_descriptor_table_core.sv =====
// page-region descriptor table top level: sequencer, scans, present masks
// depends on prdt_pkg and prdt_ram
// steps: a free-region record goes through S_REC, S_INS_RD and S_INS_WR, or from S_REC
// straight to the response when the table is full; an allocated record first scans the slots
// at one descriptor ram read a cycle until it finds one to extend or passes the last, then
// inserts; allocate scans, then records the page; one transfer at a time, the next accepted
// only back in S_IDLE once the response is loaded
// reset: synchronous, clears control, full-group mask and present-row valid bits; no sweep
module page_region_descriptor_table_core #(
   parameter int GROUPS          = prdt_pkg::GROUPS_DEF,
   parameter int SLOTS_PER_GROUP = prdt_pkg::SLOTS_PER_GROUP_DEF,
   parameter int FRAME_BITS      = prdt_pkg::FRAME_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // op, frame, page_count, is_allocated, zero fill
   input  logic [((2*FRAME_BITS+2+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // page_frame, status, merged, zero fill
   output logic [((FRAME_BITS+3+7)/8)*8-1:0] rsp_tdata
);

   localparam int FB  = FRAME_BITS;
   localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SW  = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
   localparam int AW  = GW + SW;
   localparam int DW  = 2*FB + 1;
   localparam int PD  = 2**GW;
   localparam int SPG = SLOTS_PER_GROUP;
   localparam int OW  = ((FB+3+7)/8)*8;

   prdt_pkg::state_type state_ff, state_in;

   logic          op_ff, op_in;
   logic [FB-1:0] frame_ff, frame_in;
   logic [FB-1:0] count_ff, count_in;
   logic          alloc_ff, alloc_in;
   logic [FB-1:0] page_ff, page_in;
   logic [GW-1:0] g_ff, g_in;
   logic [SW-1:0] s_ff, s_in;
   logic          more_ff, more_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          chk_last_ff, chk_last_in;
   logic [GW-1:0] chk_g_ff, chk_g_in;
   logic [SW-1:0] chk_s_ff, chk_s_in;
   logic [GW-1:0] ins_g_ff, ins_g_in;
   logic [GROUPS-1:0] full_ff, full_in;
   logic [PD-1:0] pvld_ff, pvld_in;
   logic          prd_vld_ff;

   logic          rsp_vld_ff, rsp_vld_in;
   logic [FB-1:0] rsp_page_ff, rsp_page_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_merged_ff, rsp_merged_in;

   // descriptor ram: {taken, length, base}
   logic          d_we;
   logic [AW-1:0] d_waddr;
   logic [DW-1:0] d_wdata;
   logic [DW-1:0] d_rdata;
   logic          p_we;
   logic [GW-1:0] p_waddr;
   logic [SPG-1:0] p_wdata;
   logic [GW-1:0] p_raddr;
   logic [SPG-1:0] p_rdata;
   logic [SPG-1:0] pres;

   logic [FB-1:0] d_base, d_len, d_left;
   logic          d_taken;
   logic          p_bit, m_hit, a_hit, hit;
   logic          table_full;
   logic          s_last, g_last;
   logic [GW-1:0] free_g;
   logic [SW-1:0] free_s;
   logic [SPG-1:0] pres_set;
   logic          fin;
   logic [1:0]    fin_status;
   logic          fin_merged;

   prdt_ram #(.WIDTH(DW), .AW(AW)) u_desc_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr ({g_ff, s_ff}),
      .rd_data (d_rdata)
   );

   prdt_ram #(.WIDTH(SPG), .AW(GW)) u_pres_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   // a present row never written reads as empty
   assign pres = prd_vld_ff ? p_rdata : '0;

   assign d_base  = d_rdata[FB-1:0];
   assign d_len   = d_rdata[2*FB-1:FB];
   assign d_taken = d_rdata[2*FB];
   assign d_left  = d_len - FB'(1);

   assign p_bit = pres[chk_s_ff];
   assign m_hit = p_bit & d_taken & (FB'(d_base + d_len) == frame_ff);
   assign a_hit = p_bit & ~d_taken & (d_len != '0);
   assign hit   = (state_ff == prdt_pkg::S_MSCAN) ? m_hit : a_hit;

   assign table_full = &full_ff;
   assign s_last = (s_ff == SW'(SPG-1));
   assign g_last = (g_ff == GW'(GROUPS-1));

   // first non-full group
   always_comb begin
      free_g = '0;
      for (int i = GROUPS-1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_g = GW'(i);
         end
      end
   end

   // first free slot of the row just read
   always_comb begin
      free_s = '0;
      for (int i = SPG-1; i >= 0; i--) begin
         if (!pres[i]) begin
            free_s = SW'(i);
         end
      end
   end

   always_comb begin
      pres_set = pres;
      pres_set[free_s] = 1'b1;
   end

   assign p_raddr = (state_ff == prdt_pkg::S_INS_RD) ? free_g : g_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      frame_in    = frame_ff;
      count_in    = count_ff;
      alloc_in    = alloc_ff;
      page_in     = page_ff;
      g_in        = g_ff;
      s_in        = s_ff;
      more_in     = 1'b0;
      chk_vld_in  = 1'b0;
      chk_last_in = 1'b0;
      chk_g_in    = g_ff;
      chk_s_in    = s_ff;
      ins_g_in    = ins_g_ff;
      full_in     = full_ff;
      pvld_in     = pvld_ff;
      d_we        = 1'b0;
      d_waddr     = {chk_g_ff, chk_s_ff};
      d_wdata     = d_rdata;
      p_we        = 1'b0;
      p_waddr     = chk_g_ff;
      p_wdata     = pres;
      fin         = 1'b0;
      fin_status  = prdt_pkg::ST_OK;
      fin_merged  = 1'b0;

      unique case (state_ff) inside
         prdt_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in    = req_tdata[0];
               frame_in = req_tdata[FB:1];
               count_in = req_tdata[2*FB:FB+1];
               alloc_in = req_tdata[2*FB+1];
               page_in  = '0;
               g_in     = '0;
               s_in     = '0;
               more_in  = 1'b1;
               state_in = (req_tdata[0] == prdt_pkg::OP_ALLOC) ? prdt_pkg::S_ASCAN
                                                               : prdt_pkg::S_REC;
            end
         end
         prdt_pkg::S_REC: begin
            g_in    = '0;
            s_in    = '0;
            more_in = 1'b1;
            if (table_full) begin
               fin        = 1'b1;
               fin_status = prdt_pkg::ST_FULL;
               state_in   = prdt_pkg::S_OUT;
            end else if (alloc_ff) begin
               state_in = prdt_pkg::S_MSCAN;
            end else begin
               state_in = prdt_pkg::S_INS_RD;
            end
         end
         prdt_pkg::S_MSCAN, prdt_pkg::S_ASCAN: begin
            // issue one read a cycle, check the previous read's data
            if (chk_vld_ff && hit) begin
               if (state_ff == prdt_pkg::S_MSCAN) begin
                  d_we       = 1'b1;
                  d_wdata    = {d_taken, FB'(d_len + count_ff), d_base};
                  fin        = 1'b1;
                  fin_merged = 1'b1;
                  state_in   = prdt_pkg::S_OUT;
               end else if (d_left != '0 && table_full) begin
                  fin        = 1'b1;
                  fin_status = prdt_pkg::ST_FULL;
                  state_in   = prdt_pkg::S_OUT;
               end else begin
                  d_we     = 1'b1;
                  d_wdata  = {1'b0, d_left, FB'(d_base + FB'(1))};
                  page_in  = d_base;
                  frame_in = d_base;
                  count_in = FB'(1);
                  alloc_in = 1'b1;
                  if (d_left == '0) begin
                     p_we     = 1'b1;
                     p_wdata  = pres;
                     p_wdata[chk_s_ff] = 1'b0;
                     full_in[chk_g_ff] = 1'b0;
                  end
                  state_in = prdt_pkg::S_REC;
               end
            end else if (chk_vld_ff && chk_last_ff) begin
               if (state_ff == prdt_pkg::S_MSCAN) begin
                  state_in = prdt_pkg::S_INS_RD;
               end else begin
                  fin        = 1'b1;
                  fin_status = prdt_pkg::ST_NO_PAGE;
                  state_in   = prdt_pkg::S_OUT;
               end
            end else begin
               chk_vld_in  = more_ff;
               chk_last_in = s_last && g_last;
               more_in     = more_ff && !(s_last && g_last);
               if (more_ff) begin
                  if (s_last) begin
                     s_in = '0;
                     g_in = g_ff + GW'(1);
                  end else begin
                     s_in = s_ff + SW'(1);
                  end
               end
            end
         end
         prdt_pkg::S_INS_RD: begin
            ins_g_in = free_g;
            state_in = prdt_pkg::S_INS_WR;
         end
         prdt_pkg::S_INS_WR: begin
            d_we    = 1'b1;
            d_waddr = {ins_g_ff, free_s};
            d_wdata = {alloc_ff, count_ff, frame_ff};
            p_we    = 1'b1;
            p_waddr = ins_g_ff;
            p_wdata = pres_set;
            pvld_in[ins_g_ff] = 1'b1;
            if (&pres_set) begin
               full_in[ins_g_ff] = 1'b1;
            end
            fin      = 1'b1;
            state_in = prdt_pkg::S_OUT;
         end
         prdt_pkg::S_OUT: begin
            state_in = prdt_pkg::S_IDLE;
         end
         default: begin
            state_in = prdt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_merged_in = rsp_merged_ff;
      if (fin) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = fin_status;
         rsp_merged_in = fin_merged;
         rsp_page_in   = (op_ff == prdt_pkg::OP_ALLOC && fin_status == prdt_pkg::ST_OK)
                         ? page_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prdt_pkg::S_IDLE;
         more_ff    <= 1'b0;
         chk_vld_ff <= 1'b0;
         full_ff    <= '0;
         pvld_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         more_ff    <= more_in;
         chk_vld_ff <= chk_vld_in;
         full_ff    <= full_in;
         pvld_ff    <= pvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff         <= op_in;
      frame_ff      <= frame_in;
      count_ff      <= count_in;
      alloc_ff      <= alloc_in;
      page_ff       <= page_in;
      g_ff          <= g_in;
      s_ff          <= s_in;
      chk_last_ff   <= chk_last_in;
      chk_g_ff      <= chk_g_in;
      chk_s_ff      <= chk_s_in;
      ins_g_ff      <= ins_g_in;
      prd_vld_ff    <= pvld_ff[p_raddr];
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   // a new transfer only while the result register is free or draining
   assign req_tready = (state_ff == prdt_pkg::S_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OW'({rsp_merged_ff, rsp_status_ff, rsp_page_ff});

endmodule

// ===== test/page_region_descriptor_table_core_tb.sv =====
// testbench for page_region_descriptor_table_core: directed rows, random traffic, merges
// depends on prdt_pkg and the core rtl; predicts each response with its own table copy
`timescale 1ns / 1ps

module page_region_descriptor_table_core_tb;

   localparam int NG = prdt_pkg::GROUPS_DEF;
   localparam int NS = prdt_pkg::SLOTS_PER_GROUP_DEF;
   localparam int FB = prdt_pkg::FRAME_BITS_DEF;
   localparam int NDESC = NG * NS;
   localparam int REQ_W = ((2*FB+2+7)/8)*8;
   localparam int RSP_W = ((FB+3+7)/8)*8;
   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_ITEMS = 110;

   typedef logic [FB-1:0] frame_type;

   typedef struct {
      frame_type  page_frame;
      logic [1:0] status;
      logic       merged;
   } rsp_fields_type;

   typedef struct {
      logic           op;
      frame_type      frame;
      frame_type      count;
      logic           alloc;
      bit             typed;
      rsp_fields_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // op, frame, page_count, is_allocated, zero fill
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // page_frame, status, merged, zero fill
   logic [RSP_W-1:0] rsp_tdata;

   // shadow copy of the descriptor table
   frame_type  desc_base [NDESC];
   frame_type  desc_len  [NDESC];
   bit         desc_taken[NDESC];
   logic [NS-1:0] group_present[NG];
   logic [NG-1:0] full_groups;

   rsp_fields_type  rsp_expected[$];
   stim_row_type    issued_rows[$];
   stim_row_type    directed[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  hold_rsp = 1'b0;
   bit  calm = 1'b0;

   page_region_descriptor_table_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic store_region(input frame_type f, input frame_type c, input bit al,
                               output logic [1:0] st, output logic mg);
      int g;
      int s;
      mg = 1'b0;
      st = prdt_pkg::ST_OK;
      if (full_groups == '1) begin
         st = prdt_pkg::ST_FULL;
         return;
      end
      if (al) begin
         for (int i = 0; i < NDESC; i++) begin
            if (group_present[i/NS][i%NS] && desc_taken[i] &&
                frame_type'(desc_base[i] + desc_len[i]) == f) begin
               desc_len[i] = desc_len[i] + c;
               mg = 1'b1;
               return;
            end
         end
      end
      for (int i = 0; i < NDESC; i++) begin
         g = i / NS;
         s = i % NS;
         if (!full_groups[g] && !group_present[g][s]) begin
            group_present[g][s] = 1'b1;
            if (group_present[g] == '1) full_groups[g] = 1'b1;
            desc_base[i] = f;
            desc_len[i] = c;
            desc_taken[i] = al;
            return;
         end
      end
      st = prdt_pkg::ST_FULL;
   endtask

   task automatic predict_response(input logic op, input frame_type f, input frame_type c,
                                   input logic al, output rsp_fields_type r);
      int hit;
      frame_type left;
      r.page_frame = '0;
      r.status = prdt_pkg::ST_OK;
      r.merged = 1'b0;
      hit = -1;
      if (op == prdt_pkg::OP_RECORD) begin
         store_region(f, c, al, r.status, r.merged);
      end else begin
         for (int i = 0; i < NDESC && hit < 0; i++)
            if (group_present[i/NS][i%NS] && !desc_taken[i] && desc_len[i] != 0) hit = i;
         if (hit < 0) begin
            r.status = prdt_pkg::ST_NO_PAGE;
         end else begin
            left = desc_len[hit] - 1'b1;
            if (left != 0 && full_groups == '1) begin
               r.status = prdt_pkg::ST_FULL;
            end else begin
               r.page_frame = desc_base[hit];
               desc_base[hit] = desc_base[hit] + 1'b1;
               desc_len[hit] = left;
               if (left == 0) begin
                  group_present[hit/NS][hit%NS] = 1'b0;
                  full_groups[hit/NS] = 1'b0;
               end
               store_region(r.page_frame, frame_type'(1), 1'b1, r.status, r.merged);
            end
         end
      end
      if (r.status != prdt_pkg::ST_OK) begin
         r.page_frame = '0;
         r.merged = 1'b0;
      end
   endtask

   // accepted transfers on both channels
   always @(posedge clock) begin
      rsp_fields_type r;
      rsp_fields_type w;
      stim_row_type row;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("page_region_descriptor_table_core verification failed");
            $finish;
         end
         if (req_tvalid && req_tready) begin
            row = issued_rows.pop_front();
            predict_response(req_tdata[0], req_tdata[FB:1], req_tdata[2*FB:FB+1],
                             req_tdata[2*FB+1], r);
            rsp_expected.push_back(row.typed ? row.want : r);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               report("unexpected response", rsp_tdata, '0);
            end else begin
               w = rsp_expected.pop_front();
               if (rsp_tdata[FB-1:0] !== w.page_frame)
                  report("page_frame", rsp_tdata[FB-1:0], w.page_frame);
               if (rsp_tdata[FB+1:FB] !== w.status)
                  report("status", rsp_tdata[FB+1:FB], w.status);
               if (rsp_tdata[FB+2] !== w.merged)
                  report("merged", rsp_tdata[FB+2], w.merged);
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = (calm || $urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(20, 100));
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send(input stim_row_type row);
      req_tdata <= REQ_W'({row.alloc, row.count, row.frame, row.op});
      req_tvalid <= 1'b1;
      issued_rows.push_back(row);
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      idle_gap();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_expected.size() != 0 || issued_rows.size() != 0) @(posedge clock);
   endtask

   function automatic frame_type rand_frame();
      return {$urandom(), 8'($urandom())};
   endfunction

   function automatic frame_type rand_count();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return '1;
      if (k == 1) return rand_frame();
      return frame_type'($urandom_range(0, 6));
   endfunction

   function automatic stim_row_type mk(input logic op, input frame_type f, input frame_type c,
                                       input logic al, input bit typed = 0,
                                       input frame_type pf = '0,
                                       input logic [1:0] st = prdt_pkg::ST_OK,
                                       input logic mg = 1'b0);
      stim_row_type row;
      row.op = op; row.frame = f; row.count = c; row.alloc = al; row.typed = typed;
      row.want.page_frame = pf; row.want.status = st; row.want.merged = mg;
      return row;
   endfunction

   // frame that ends some allocated descriptor, so the record merges
   function automatic frame_type merge_frame();
      int start;
      int i;
      start = $urandom_range(0, NDESC - 1);
      for (int k = 0; k < NDESC; k++) begin
         i = (start + k) % NDESC;
         if (group_present[i/NS][i%NS] && desc_taken[i])
            return frame_type'(desc_base[i] + desc_len[i]);
      end
      return rand_frame();
   endfunction

   always begin
      @(posedge clock);
      if (!reset) begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (1500) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (calm || $urandom_range(0, 9) < 6) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(20, 80))
               @(posedge clock);
         end
      end
   end

   initial begin
      int k;
      frame_type f;
      for (int g = 0; g < NG; g++) group_present[g] = '0;
      full_groups = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b0, 1, '0,
                            prdt_pkg::ST_NO_PAGE, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_RECORD, '1, '0, 1'b0, 1, '0,
                            prdt_pkg::ST_OK, 1'b0));
      // a free descriptor of length zero holds no page
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b0, 1, '0,
                            prdt_pkg::ST_NO_PAGE, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_RECORD, '1, '1, 1'b1, 1, '0,
                            prdt_pkg::ST_OK, 1'b0));
      // end wraps: max + max
      directed.push_back(mk(prdt_pkg::OP_RECORD, {{(FB-1){1'b1}}, 1'b0}, frame_type'(5), 1'b1,
                            1, '0, prdt_pkg::ST_OK, 1'b1));
      // zero-count merge still flags merged
      directed.push_back(mk(prdt_pkg::OP_RECORD, frame_type'(3), '0, 1'b1, 1, '0,
                            prdt_pkg::ST_OK, 1'b1));
      // free region never merges
      directed.push_back(mk(prdt_pkg::OP_RECORD, frame_type'(3), frame_type'(2), 1'b0, 1, '0,
                            prdt_pkg::ST_OK, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '1, '1, 1'b1));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b0, 1, '0,
                            prdt_pkg::ST_NO_PAGE, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_RECORD, '0, frame_type'(1), 1'b0));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_RECORD, {(FB/2){2'b01}}, {(FB/2){2'b10}}, 1'b1));
      directed.push_back(mk(prdt_pkg::OP_RECORD, {(FB/2){2'b10}}, {(FB/2){2'b01}}, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '1, '1, 1'b1));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, {(FB/2){2'b10}}, '0, 1'b0));
      directed.push_back(mk(prdt_pkg::OP_RECORD, '1, frame_type'(1), 1'b0));
      directed.push_back(mk(prdt_pkg::OP_ALLOC, '0, '0, 1'b1));
      directed.push_back(mk(prdt_pkg::OP_RECORD, frame_type'(1), frame_type'(1), 1'b1));
      foreach (directed[i]) send(directed[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 30) hold_rsp = 1'b1;
         if (n == 70) wait_drained();
         k = $urandom_range(0, 9);
         // short free records keep offering while the receiver holds off
         if (n == 30 || n == 31)
            send(mk(prdt_pkg::OP_RECORD, rand_frame(), rand_count(), 1'b0));
         else if (k < 3)
            send(mk(prdt_pkg::OP_ALLOC, rand_frame(), rand_count(), 1'($urandom())));
         else if (k < 6) begin
            wait_drained();
            f = merge_frame();
            send(mk(prdt_pkg::OP_RECORD, f, rand_count(), 1'b1));
         end else send(mk(prdt_pkg::OP_RECORD, rand_frame(), rand_count(), 1'($urandom())));
      end

      // merge onto a live descriptor, then drain free pages
      wait_drained();
      f = merge_frame();
      send(mk(prdt_pkg::OP_RECORD, f, frame_type'(4), 1'b1));
      for (int n = 0; n < 8; n++) send(mk(prdt_pkg::OP_ALLOC, rand_frame(), '0, 1'b0));
      send(mk(prdt_pkg::OP_RECORD, rand_frame(), rand_count(), 1'($urandom())));

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && rsp_expected.size() == 0)
         $display("page_region_descriptor_table_core verification clean");
      else
         $display("page_region_descriptor_table_core verification failed");
      $finish;
   end

endmodule
